[hw/rtl/fldr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldr_pkg: shared types and constants of the line and disc raster engine
// Holds command codes, register indexes and the word passed from the front
// (command decode) to the back (pixel walker).
// ----------------------------------------------------------------------------
package fldr_pkg;

	typedef enum logic [1:0] {
		FUNC_DISC  = 2'd0,
		FUNC_LINE  = 2'd1,
		FUNC_BLEND = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// command word as classified by the front part
	typedef struct packed {
		func_t              func;
		logic signed [10:0] x0;
		logic signed [10:0] y0;
		logic signed [10:0] x1;
		logic signed [10:0] y1;
		logic        [6:0]  radius;  // disc radius, or line stroke radius
		logic               thin;    // line with stroke of one
		logic               zero_len; // line of no length
		logic        [7:0]  alpha;
		logic        [23:0] color;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_LDIV,
		BK_LPOINT,
		BK_DISC,
		BK_DRD,
		BK_BRD,
		BK_BWAIT,
		BK_BMIX,
		BK_BDIV,
		BK_DONE
	} bk_state_t;

endpackage

[hw/rtl/fldr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldr_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module fldr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hw/rtl/fldr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldr_front: command decode and two-entry queue
// Accepts commands, works out stroke radius and line kind, and queues the
// classified word for the back part.
// ----------------------------------------------------------------------------
module fldr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic signed [9:0]   x_start,
	input  logic signed [9:0]   y_start,
	input  logic signed [9:0]   x_end,
	input  logic signed [9:0]   y_end,
	input  logic [5:0]          size,
	input  logic [7:0]          alpha,
	input  logic [23:0]         color,
	output logic                q_valid,
	input  logic                q_pop,
	output fldr_pkg::cmd_t      q_word
);

	fldr_pkg::cmd_t  cmd;
	fldr_pkg::cmd_t  queue_q [2];
	logic            rd_ptr_q;
	logic            wr_ptr_q;
	logic [1:0]      count_q;
	logic [5:0]      stroke;
	logic            push;

	// classify the command
	always_comb begin
		stroke        = (size == 6'd0) ? 6'd1 : size;
		cmd.func      = fldr_pkg::func_t'(func);
		cmd.x0        = 11'(x_start);
		cmd.y0        = 11'(y_start);
		cmd.x1        = 11'(x_end);
		cmd.y1        = 11'(y_end);
		cmd.zero_len  = (x_start == x_end) && (y_start == y_end);
		cmd.thin      = (stroke == 6'd1);
		cmd.alpha     = alpha;
		cmd.color     = color;
		if (fldr_pkg::func_t'(func) == fldr_pkg::FUNC_DISC) begin
			cmd.radius = {1'b0, size};
		end else if (cmd.zero_len) begin
			cmd.radius = 7'({2'b0, stroke[5:1]} + 7'd1);
		end else begin
			cmd.radius = {2'b0, stroke[5:1]};
		end
	end

	assign busy    = count_q[1];
	assign push    = start && !busy;
	assign q_valid = count_q != 2'd0;
	assign q_word  = queue_q[rd_ptr_q];

	// hold queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, q_pop});
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> count_q != 2'd0)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !q_pop) |=> busy)
		else $error("full queue not reported busy");

endmodule

[hw/rtl/fldr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldr_back: pixel walker
// Clears the frame store after reset, then runs queued commands: disc
// scan, DDA line with a serial divider, blend with a serial /255, read.
// ----------------------------------------------------------------------------
module fldr_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [6:0]          width_in_use,
	input  logic [6:0]          height_in_use,
	input  logic                q_valid,
	output logic                q_pop,
	input  fldr_pkg::cmd_t      q_word,
	output logic                done,
	output logic [23:0]         read_data,
	output logic [15:0]         pixels_written
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = 12;

	fldr_pkg::bk_state_t state_q, state_d;
	fldr_pkg::cmd_t      cmd_q;

	logic [AW-1:0]        clr_q;
	logic signed [CW-1:0] w_eff, h_eff;
	// disc scan
	logic signed [CW-1:0] cx_q, cy_q, dx_q, dy_q;
	logic                 disc_of_line_q;
	// line walk
	logic signed [31:0]   fx_q, fy_q, xi_q, yi_q;
	logic [10:0]          steps_q, i_q;
	// serial divider for |d|*65536/steps
	logic [27:0]          rem_q;
	logic [27:0]          qx_q, qy_q;
	logic [4:0]           dcnt_q;
	logic                 dsel_q;
	logic [26:0]          num_q;
	// blend
	logic [23:0]          bg_q;
	logic [1:0]           ch_q;
	logic [16:0]          mix_q;
	logic [7:0]           qch_q;
	logic [23:0]          res_q;
	logic [15:0]          cnt_q;
	logic [23:0]          rd_q;

	logic                 we;
	logic [AW-1:0]        addr;
	logic [23:0]          wdata;
	logic [23:0]          rdata;

	// clip registers to the maximum
	assign w_eff = (32'(width_in_use) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_in_use);
	assign h_eff = (32'(height_in_use) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(height_in_use);

	fldr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// pixel tests
	logic signed [CW-1:0] px, py;
	logic signed [CW-1:0] lo, hi;
	logic signed [23:0]   dsq, r2;
	logic                 in_area;
	logic [23:0]          lin;
	logic [23:0]          pt_lin;
	logic [23:0]          cen_lin;
	logic signed [31:0]   rx, ry;
	logic signed [CW-1:0] lpx, lpy;
	logic signed [CW-1:0] rad;
	logic [7:0]           sch, dch;
	logic [27:0]          dv_cat, dv_quo;
	logic                 dv_ge;

	always_comb begin
		rad     = CW'($signed({1'b0, cmd_q.radius}));
		px      = cx_q + dx_q;
		py      = cy_q + dy_q;
		dsq     = 24'(dx_q) * 24'(dx_q) + 24'(dy_q) * 24'(dy_q);
		r2      = 24'(rad) * 24'(rad);
		in_area = px >= 0 && py >= 0 && px < w_eff && py < h_eff;
		lin     = 24'(py) * 24'(w_eff) + 24'(px);
		cen_lin = 24'(cy_q) * 24'(w_eff) + 24'(cx_q);
		rx      = fx_q + 32'sd32768;
		ry      = fy_q + 32'sd32768;
		// truncate toward zero
		lpx     = (rx < 0) ? -CW'((-rx) >>> 16) : CW'(rx >>> 16);
		lpy     = (ry < 0) ? -CW'((-ry) >>> 16) : CW'(ry >>> 16);
		pt_lin  = 24'(lpy) * 24'(w_eff) + 24'(lpx);
		// clipped row bounds
		lo      = (-rad < -cx_q) ? -cx_q : -rad;
		hi      = (rad > w_eff - 1 - cx_q) ? w_eff - 1 - cx_q : rad;
		sch     = cmd_q.color[8*ch_q +: 8];
		dch     = bg_q[8*ch_q +: 8];
		// one restoring divider step
		dv_cat  = {rem_q[26:0], num_q[dcnt_q]};
		dv_ge   = dv_cat >= {17'd0, steps_q};
		dv_quo  = {qx_q[26:0], dv_ge};
	end

	// next state and memory port
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		we      = 1'b0;
		addr    = AW'(lin);
		wdata   = cmd_q.color;
		case (state_q)
			fldr_pkg::BK_CLEAR: begin
				we    = 1'b1;
				addr  = clr_q;
				wdata = '0;
				if (32'(clr_q) == DEPTH - 1) begin
					state_d = fldr_pkg::BK_IDLE;
				end
			end
			fldr_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_word.func)
						fldr_pkg::FUNC_DISC:  state_d = fldr_pkg::BK_DISC;
						fldr_pkg::FUNC_LINE:  state_d = q_word.zero_len ?
							fldr_pkg::BK_DISC : fldr_pkg::BK_LDIV;
						fldr_pkg::FUNC_BLEND: state_d = fldr_pkg::BK_BRD;
						default:              state_d = fldr_pkg::BK_DRD;
					endcase
				end
			end
			fldr_pkg::BK_LDIV: begin
				if (dcnt_q == 5'd0 && dsel_q) begin
					state_d = fldr_pkg::BK_LPOINT;
				end
			end
			fldr_pkg::BK_LPOINT: begin
				addr = AW'(pt_lin);
				if (cmd_q.thin) begin
					we = lpx >= 0 && lpy >= 0 && lpx < w_eff && lpy < h_eff
						&& 32'(pt_lin) < DEPTH;
					if (i_q == steps_q) begin
						state_d = fldr_pkg::BK_DONE;
					end
				end else begin
					state_d = fldr_pkg::BK_DISC;
				end
			end
			fldr_pkg::BK_DISC: begin
				if (rad <= 0) begin
					state_d = fldr_pkg::BK_DONE;
				end else begin
					we = in_area && dsq <= r2 && dx_q >= lo && dx_q <= hi
						&& 32'(lin) < DEPTH;
					if (dy_q >= rad && dx_q >= rad) begin
						state_d = (disc_of_line_q && i_q != steps_q) ?
							fldr_pkg::BK_LPOINT : fldr_pkg::BK_DONE;
					end
				end
			end
			fldr_pkg::BK_DRD: begin
				addr = AW'(cen_lin);
				state_d = fldr_pkg::BK_DONE;
			end
			fldr_pkg::BK_BRD: begin
				addr = AW'(cen_lin);
				if (!(cx_q >= 0 && cy_q >= 0 && cx_q < w_eff && cy_q < h_eff)
					|| cmd_q.alpha == 8'd0) begin
					state_d = fldr_pkg::BK_DONE;
				end else if (cmd_q.alpha == 8'hFF) begin
					we = 32'(cen_lin) < DEPTH;
					state_d = fldr_pkg::BK_DONE;
				end else begin
					state_d = fldr_pkg::BK_BWAIT;
				end
			end
			fldr_pkg::BK_BWAIT: begin
				state_d = fldr_pkg::BK_BMIX;
			end
			fldr_pkg::BK_BMIX: begin
				state_d = fldr_pkg::BK_BDIV;
			end
			fldr_pkg::BK_BDIV: begin
				addr  = AW'(cen_lin);
				wdata = res_q;
				if (mix_q < 17'd255 && ch_q == 2'd2) begin
					// red lands in this cycle, take it straight from the quotient
					wdata = {qch_q, res_q[15:0]};
					we = 32'(cen_lin) < DEPTH;
					state_d = fldr_pkg::BK_DONE;
				end else if (mix_q < 17'd255) begin
					state_d = fldr_pkg::BK_BMIX;
				end
			end
			fldr_pkg::BK_DONE: begin
				state_d = fldr_pkg::BK_IDLE;
			end
			default: state_d = fldr_pkg::BK_IDLE;
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fldr_pkg::BK_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fldr_pkg::BK_CLEAR) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
		end
	end

	// datapath registers
	logic [10:0] adx, ady, cady;
	always_comb begin
		adx  = (q_word.x1 >= q_word.x0) ? 11'(q_word.x1 - q_word.x0) : 11'(q_word.x0 - q_word.x1);
		ady  = (q_word.y1 >= q_word.y0) ? 11'(q_word.y1 - q_word.y0) : 11'(q_word.y0 - q_word.y1);
		cady = (cmd_q.y1 >= cmd_q.y0) ? 11'(cmd_q.y1 - cmd_q.y0) : 11'(cmd_q.y0 - cmd_q.y1);
	end

	always_ff @(posedge clk) begin
		if (we && cnt_q != 16'hFFFF) begin
			cnt_q <= cnt_q + 16'd1;
		end
		case (state_q)
			fldr_pkg::BK_IDLE: begin
				cmd_q          <= q_word;
				cnt_q          <= '0;
				rd_q           <= '0;
				cx_q           <= CW'(q_word.x0);
				cy_q           <= CW'(q_word.y0);
				dy_q           <= -CW'($signed({1'b0, q_word.radius}));
				dx_q           <= -CW'($signed({1'b0, q_word.radius}));
				disc_of_line_q <= q_word.func == fldr_pkg::FUNC_LINE && !q_word.zero_len;
				steps_q        <= (adx > ady) ? adx : ady;
				i_q            <= '0;
				fx_q           <= 32'(q_word.x0) <<< 16;
				fy_q           <= 32'(q_word.y0) <<< 16;
				num_q          <= {adx, 16'd0};
				rem_q          <= '0;
				qx_q           <= '0;
				dcnt_q         <= 5'd26;
				dsel_q         <= 1'b0;
				ch_q           <= '0;
				res_q          <= '0;
			end
			fldr_pkg::BK_LDIV: begin
				// restoring division, one bit a cycle
				if (dcnt_q == 5'd0 && !dsel_q) begin
					// x quotient complete, start on the y delta
					qy_q   <= dv_quo;
					dsel_q <= 1'b1;
					dcnt_q <= 5'd26;
					num_q  <= {cady, 16'd0};
					rem_q  <= '0;
					qx_q   <= '0;
				end else begin
					rem_q <= dv_ge ? dv_cat - {17'd0, steps_q} : dv_cat;
					qx_q  <= dv_quo;
					if (dcnt_q == 5'd0) begin
						xi_q <= (cmd_q.x1 < cmd_q.x0) ? -$signed(32'(qy_q)) : $signed(32'(qy_q));
						yi_q <= (cmd_q.y1 < cmd_q.y0) ? -$signed(32'(dv_quo)) :
							$signed(32'(dv_quo));
					end else begin
						dcnt_q <= dcnt_q - 5'd1;
					end
				end
			end
			fldr_pkg::BK_LPOINT: begin
				if (cmd_q.thin) begin
					fx_q <= fx_q + xi_q;
					fy_q <= fy_q + yi_q;
					i_q  <= i_q + 11'd1;
				end else begin
					cx_q <= lpx;
					cy_q <= lpy;
					dx_q <= -rad;
					dy_q <= -rad;
					fx_q <= fx_q + xi_q;
					fy_q <= fy_q + yi_q;
				end
			end
			fldr_pkg::BK_DISC: begin
				if (dx_q >= rad) begin
					dx_q <= -rad;
					dy_q <= dy_q + 1;
					if (dy_q >= rad) begin
						i_q <= i_q + 11'd1;
					end
				end else begin
					dx_q <= dx_q + 1;
				end
			end
			fldr_pkg::BK_DRD: begin
				// read data lands in BK_DONE
			end
			fldr_pkg::BK_BWAIT: begin
				bg_q <= rdata;
			end
			fldr_pkg::BK_BMIX: begin
				mix_q <= 17'(sch) * 17'(cmd_q.alpha) + 17'(dch) * 17'(8'hFF - cmd_q.alpha);
				qch_q <= '0;
			end
			fldr_pkg::BK_BDIV: begin
				// divide by 255 by repeated subtraction of 255 * 2^k
				if (mix_q >= 17'(255 << 7)) begin
					mix_q <= mix_q - 17'(255 << 7);
					qch_q <= qch_q + 8'd128;
				end else if (mix_q >= 17'(255 << 5)) begin
					mix_q <= mix_q - 17'(255 << 5);
					qch_q <= qch_q + 8'd32;
				end else if (mix_q >= 17'(255 << 3)) begin
					mix_q <= mix_q - 17'(255 << 3);
					qch_q <= qch_q + 8'd8;
				end else if (mix_q >= 17'd255) begin
					mix_q <= mix_q - 17'd255;
					qch_q <= qch_q + 8'd1;
				end else begin
					res_q[8*ch_q +: 8] <= qch_q;
					ch_q <= ch_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (state_q == fldr_pkg::BK_DONE && cmd_q.func == fldr_pkg::FUNC_READ
			&& cx_q >= 0 && cy_q >= 0 && cx_q < w_eff && cy_q < h_eff) begin
			rd_q <= rdata;
		end
	end

	// drive the result in the cycle after DONE
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= state_q == fldr_pkg::BK_DONE;
		end
	end

	assign done           = done_q;
	assign read_data      = rd_q;
	assign pixels_written = cnt_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q != fldr_pkg::BK_IDLE)
		else $error("write while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == fldr_pkg::BK_IDLE)
		else $error("pop while walking");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == fldr_pkg::BK_DONE)
		else $error("stray result strobe");

endmodule

[hw/rtl/framebuffer_line_disc_raster.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_line_disc_raster: disc, line, blend and read over a frame store
// Top level: register port, command front and pixel walking back.
//
//  channel   | handshake          | word
//  command   | start / busy       | func, coordinates, size, alpha, color
//  result    | done (one cycle)   | read_data, pixels_written
//  register  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A disc scans its (2r+1)^2 square; a line runs the serial divider, then
// plots each point or scans a disc around it; blend reads, mixes and divides
// per channel; read fetches one word. The strobe follows DONE in the next
// cycle. After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT entries;
// commands queue meanwhile. Up to two commands wait; busy stalls the sender.
// ----------------------------------------------------------------------------
module framebuffer_line_disc_raster #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [9:0]  x_start,
	input  logic signed [9:0]  y_start,
	input  logic signed [9:0]  x_end,
	input  logic signed [9:0]  y_end,
	input  logic [5:0]         size,
	input  logic [7:0]         alpha,
	input  logic [23:0]        color,
	output logic               done,
	output logic [23:0]        read_data,
	output logic [15:0]        pixels_written,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	logic [6:0]     width_q, height_q;
	logic           q_valid, q_pop;
	fldr_pkg::cmd_t q_word;

	assign cfg_ready = 1'b1;

	// hold register values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				fldr_pkg::REG_WIDTH:  width_q  <= cfg_data;
				fldr_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fldr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.func    (func),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.size    (size),
		.alpha   (alpha),
		.color   (color),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_word  (q_word)
	);

	fldr_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.width_in_use   (width_q),
		.height_in_use  (height_q),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_word         (q_word),
		.done           (done),
		.read_data      (read_data),
		.pixels_written (pixels_written)
	);

endmodule

[tb/framebuffer_line_disc_raster_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_line_disc_raster_test: self-checking bench of the raster engine
// Drives discs, lines, blends and reads from a short directed table and then
// random bursts over several active-area settings. A behavioral frame store
// inside the bench predicts read_data and pixels_written unless a row gives them.
// ----------------------------------------------------------------------------
module framebuffer_line_disc_raster_test;

	localparam int MAX_W      = 64;
	localparam int MAX_H      = 64;
	localparam int IDLE_LIMIT = 600000;
	localparam int PHASE_LEN  = 108;

	typedef struct {
		fldr_pkg::func_t op;
		int          xs, ys, xe, ye, sz, al;
		logic [23:0] col;
		bit          typed;   // expected word given in the row
		logic [23:0] rd;
		int          cnt;
	} raster_cmd_t;

	typedef struct {
		logic [23:0] rd;
		logic [15:0] cnt;
	} raster_word_t;

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	logic [1:0] func;
	logic signed [9:0] x_start, y_start, x_end, y_end;
	logic [5:0] size;
	logic [7:0] alpha;
	logic [23:0] color, read_data;
	logic [15:0] pixels_written;
	logic [0:0] cfg_index;
	logic [6:0] cfg_data;

	framebuffer_line_disc_raster dut (.*);

	// model frame store and active area
	logic [23:0] pix_mem [MAX_W*MAX_H];
	int unsigned area_w, area_h;
	int unsigned write_tally;
	raster_word_t pending_words[$];
	int errors;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int eff_w();
		return area_w > MAX_W ? MAX_W : area_w;
	endfunction

	function automatic int eff_h();
		return area_h > MAX_H ? MAX_H : area_h;
	endfunction

	function automatic bit in_area(int x, int y);
		return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
	endfunction

	function automatic void plot(int x, int y, logic [23:0] c);
		int unsigned a;
		a = y * eff_w() + x;
		if (a < MAX_W*MAX_H) begin
			pix_mem[a] = c;
			if (write_tally < 65535) write_tally++;
		end
	endfunction

	function automatic void fill_disc(int cx, int cy, int r, logic [23:0] c);
		int lo, hi, py;
		if (r <= 0) return;
		for (int dy = -r; dy <= r; dy++) begin
			py = cy + dy;
			if (py < 0 || py >= eff_h()) continue;
			lo = (-r < -cx) ? -cx : -r;
			hi = (r > eff_w() - 1 - cx) ? eff_w() - 1 - cx : r;
			for (int dx = lo; dx <= hi; dx++)
				if (dx*dx + dy*dy <= r*r) plot(cx + dx, py, c);
		end
	endfunction

	// 16.16 step, truncated toward zero on the magnitude
	function automatic longint step_of(int d, int steps);
		longint m;
		m = longint'(d < 0 ? -d : d) * 65536 / steps;
		return d < 0 ? -m : m;
	endfunction

	function automatic void walk_line(int x0, int y0, int x1, int y1, int stroke,
			logic [23:0] c);
		int ax, ay, steps, px, py;
		longint xi, yi, fx, fy;
		ax = x1 > x0 ? x1 - x0 : x0 - x1;
		ay = y1 > y0 ? y1 - y0 : y0 - y1;
		steps = ax > ay ? ax : ay;
		if (stroke < 1) stroke = 1;
		if (steps == 0) begin
			fill_disc(x0, y0, stroke / 2 + 1, c);
			return;
		end
		xi = step_of(x1 - x0, steps);
		yi = step_of(y1 - y0, steps);
		fx = longint'(x0) * 65536;
		fy = longint'(y0) * 65536;
		for (int i = 0; i <= steps; i++) begin
			px = int'((fx + 32768) / 65536);
			py = int'((fy + 32768) / 65536);
			if (stroke == 1) begin
				if (in_area(px, py)) plot(px, py, c);
			end else begin
				fill_disc(px, py, stroke / 2, c);
			end
			fx += xi;
			fy += yi;
		end
	endfunction

	// apply one command to the model store and return its result word
	function automatic raster_word_t raster_predict(raster_cmd_t k);
		raster_word_t w;
		logic [23:0] bg, mix;
		int s, d;
		w.rd = '0;
		write_tally = 0;
		case (k.op)
			fldr_pkg::FUNC_DISC: fill_disc(k.xs, k.ys, k.sz, k.col);
			fldr_pkg::FUNC_LINE: walk_line(k.xs, k.ys, k.xe, k.ye, k.sz, k.col);
			fldr_pkg::FUNC_BLEND: begin
				if (in_area(k.xs, k.ys) && k.al > 0) begin
					if (k.al >= 255) begin
						plot(k.xs, k.ys, k.col);
					end else begin
						bg = pix_mem[k.ys * eff_w() + k.xs];
						for (int sh = 0; sh <= 16; sh += 8) begin
							s = (k.col >> sh) & 8'hFF;
							d = (bg >> sh) & 8'hFF;
							mix[sh +: 8] = 8'((s * k.al + d * (255 - k.al)) / 255);
						end
						plot(k.xs, k.ys, mix);
					end
				end
			end
			fldr_pkg::FUNC_READ: begin
				if (in_area(k.xs, k.ys)) w.rd = pix_mem[k.ys * eff_w() + k.xs];
			end
			default: begin
			end
		endcase
		w.cnt = write_tally[15:0];
		return w;
	endfunction

	// issue one command word and hold it until accepted
	task automatic issue(raster_cmd_t k);
		raster_word_t w;
		@(negedge clk);
		func    = k.op;
		x_start = k.xs[9:0];
		y_start = k.ys[9:0];
		x_end   = k.xe[9:0];
		y_end   = k.ye[9:0];
		size    = k.sz[5:0];
		alpha   = k.al[7:0];
		color   = k.col;
		start   = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		w = raster_predict(k);
		if (k.typed) begin
			w.rd  = k.rd;
			w.cnt = k.cnt[15:0];
		end
		pending_words.push_back(w);
	endtask

	task automatic drop_start(int gap);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// write one register once the engine has drained
	task automatic reg_write(logic [0:0] idx, int unsigned val);
		@(negedge clk);
		start = 1'b0;
		wait (pending_words.size() == 0);
		repeat (20) @(posedge clk);
		@(negedge clk);
		start     = 1'b0;
		cfg_index = idx;
		cfg_data  = val[6:0];
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == fldr_pkg::REG_WIDTH) area_w = val & 32'h7F;
		else area_h = val & 32'h7F;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_coord();
		if ($urandom_range(9) == 0) return int'($urandom_range(1023)) - 512;
		return int'($urandom_range(80)) - 8;
	endfunction

	function automatic raster_cmd_t random_cmd();
		raster_cmd_t k;
		k.op  = fldr_pkg::func_t'($urandom_range(3));
		k.xs  = pick_coord();
		k.ys  = pick_coord();
		k.xe  = pick_coord();
		k.ye  = pick_coord();
		case ($urandom_range(39))
			0:        k.sz = $urandom_range(63);
			1, 2, 3:  k.sz = $urandom_range(12);
			default:  k.sz = $urandom_range(4);
		endcase
		// keep wide strokes on short lines so the run stays bounded
		if (k.op == fldr_pkg::FUNC_LINE && k.sz > 4) begin
			k.xs = int'($urandom_range(80)) - 8;
			k.ys = int'($urandom_range(80)) - 8;
			k.xe = k.xs + int'($urandom_range(12)) - 6;
			k.ye = k.ys + int'($urandom_range(12)) - 6;
		end
		case ($urandom_range(7))
			0:       k.al = 0;
			1:       k.al = 255;
			default: k.al = $urandom_range(255);
		endcase
		k.col   = 24'($urandom);
		k.typed = 1'b0;
		return k;
	endfunction

	// result checker
	always @(posedge clk) begin
		raster_word_t w;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$display("%0t: result with nothing expected: read_data %h count %0d",
					$time, read_data, pixels_written);
				errors++;
			end else begin
				w = pending_words.pop_front();
				if (read_data !== w.rd) begin
					$display("%0t: read_data expected %h actual %h", $time, w.rd, read_data);
					errors++;
				end
				if (pixels_written !== w.cnt) begin
					$display("%0t: pixels_written expected %0d actual %0d",
						$time, w.cnt, pixels_written);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word or result
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("framebuffer_line_disc_raster_test: done, errors");
			$finish;
		end
	end

	raster_cmd_t dir_rows[$];

	function automatic raster_cmd_t row(fldr_pkg::func_t op, int xs, int ys, int xe, int ye,
			int sz, int al, logic [23:0] col, bit typed, logic [23:0] rd, int cnt);
		raster_cmd_t k;
		k.op = op; k.xs = xs; k.ys = ys; k.xe = xe; k.ye = ye; k.sz = sz; k.al = al;
		k.col = col; k.typed = typed; k.rd = rd; k.cnt = cnt;
		return k;
	endfunction

	initial begin
		int unsigned ws[5];
		int unsigned hs[5];
		int burst;
		ws = '{127, 0, 1, 0, 64};
		hs = '{127, 40, 1, 0, 64};
		errors = 0;
		idle_cycles = 0;
		area_w = 64;
		area_h = 64;
		foreach (pix_mem[i]) pix_mem[i] = '0;
		arst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		func = '0; x_start = '0; y_start = '0; x_end = '0; y_end = '0;
		size = '0; alpha = '0; color = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table: store cleared, blend extremes, clipping, line cases
		dir_rows = '{
			row(fldr_pkg::FUNC_READ,   0,   0, 0, 0, 0,   0, 24'h0,      1, 24'h0, 0),
			row(fldr_pkg::FUNC_BLEND,  5,   5, 0, 0, 0, 255, 24'hFFFFFF, 1, 24'h0, 1),
			row(fldr_pkg::FUNC_READ,   5,   5, 0, 0, 0,   0, 24'h0,      1, 24'hFFFFFF, 0),
			row(fldr_pkg::FUNC_BLEND,  5,   5, 0, 0, 0,   0, 24'h123456, 1, 24'h0, 0),
			row(fldr_pkg::FUNC_BLEND,  5,   5, 0, 0, 0, 128, 24'h000000, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_READ,   5,   5, 0, 0, 0,   0, 24'h0,      0, 24'h0, 0),
			row(fldr_pkg::FUNC_READ,  -1,   0, 0, 0, 0,   0, 24'h0,      1, 24'h0, 0),
			row(fldr_pkg::FUNC_READ, 511, 511, 0, 0, 0,   0, 24'h0,      1, 24'h0, 0),
			row(fldr_pkg::FUNC_BLEND, 64,   3, 0, 0, 0, 255, 24'hABCDEF, 1, 24'h0, 0),
			row(fldr_pkg::FUNC_DISC,  10,  10, 0, 0, 0,   0, 24'h00FF00, 1, 24'h0, 0),
			row(fldr_pkg::FUNC_DISC,  10,  10, 0, 0, 1,   0, 24'h00FF00, 1, 24'h0, 5),
			row(fldr_pkg::FUNC_DISC, -512, -512, 0, 0, 63, 0, 24'h0000FF, 1, 24'h0, 0),
			row(fldr_pkg::FUNC_DISC,  32,  32, 0, 0, 63,  0, 24'h5A5A5A, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_LINE,   0,   0, 9, 0, 1,   0, 24'hFF0000, 1, 24'h0, 10),
			row(fldr_pkg::FUNC_LINE,   3,   3, 3, 3, 0,   0, 24'h00FFFF, 1, 24'h0, 5),
			row(fldr_pkg::FUNC_LINE, -512, -512, 511, 511, 1, 0, 24'hA5A5A5, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_LINE, 511, -512, -512, 511, 2, 0, 24'h3C3C3C, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_LINE,   2,  40, 32, 10, 63, 0, 24'h777777, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_LINE,  20,  20, 20, 20, 63, 0, 24'h101010, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_LINE,   0,   0, 7, 3, 3,   0, 24'hC0FFEE, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_READ,  20,  20, 0, 0, 0,   0, 24'h0,      0, 24'h0, 0),
			row(fldr_pkg::FUNC_BLEND, 63,  63, 0, 0, 0, 254, 24'h123456, 0, 24'h0, 0),
			row(fldr_pkg::FUNC_READ,  63,  63, 0, 0, 0,   0, 24'h0,      0, 24'h0, 0)
		};
		foreach (dir_rows[i]) begin
			issue(dir_rows[i]);
			drop_start($urandom_range(2));
		end

		// random phases, each after the first under a new active area
		for (int ph = 0; ph <= 5; ph++) begin
			if (ph > 0) begin
				reg_write(fldr_pkg::REG_WIDTH,
					ws[ph-1] != 0 || ph != 4 ? ws[ph-1] : $urandom_range(1, 64));
				reg_write(fldr_pkg::REG_HEIGHT,
					hs[ph-1] != 0 || ph != 4 ? hs[ph-1] : $urandom_range(1, 64));
			end
			for (int n = 0; n < PHASE_LEN; n += burst) begin
				burst = $urandom_range(1, 16);
				for (int b = 0; b < burst; b++) issue(random_cmd());
				drop_start(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8));
			end
		end

		@(negedge clk);
		start = 1'b0;
		wait (pending_words.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("framebuffer_line_disc_raster_test: done, clean");
		else
			$display("framebuffer_line_disc_raster_test: done, errors");
		$finish;
	end

endmodule
